FILE: rtl/core/rms_pkg.sv
`timescale 1ns / 1ps

package rms_pkg;

  localparam int SAMPLE_W   = 16;  // signed Q1.15 sample
  localparam int RMS_W      = 16;  // unsigned Q1.15 result
  localparam int COUNT_W    = 13;  // reported sample count
  localparam int MEAN_W     = 31;  // mean square, unsigned Q1.30, at most 2^30
  localparam int ROOT_STEPS = 16;  // one result bit per step
  localparam int STEP_W     = $clog2(MEAN_W);

  // Highest even power of two that a mean can reach
  localparam logic [MEAN_W-1:0] ROOT_TOP = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef struct packed {
    logic close;      // last square lands; latch totals into divider
    logic div_step;   // one restoring division step
    logic root_step;  // one square root step
    logic out_load;   // move result into the output register
  } rms_cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or draining this cycle
  } rms_status_t;

endpackage

FILE: rtl/core/rms_in_if.sv
`timescale 1ns / 1ps

interface rms_in_if;
  import rms_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: rtl/core/rms_out_if.sv
`timescale 1ns / 1ps

interface rms_out_if;
  import rms_pkg::*;

  logic               valid;
  logic               ready;
  logic [RMS_W-1:0]   rms;
  logic [COUNT_W-1:0] sample_count;
  logic               too_long;

  modport source (output valid, output rms, output sample_count, output too_long,
                  input ready);
  modport sink   (input valid, input rms, input sample_count, input too_long,
                  output ready);
endinterface

FILE: rtl/core/rms_ctrl.sv
`timescale 1ns / 1ps

module rms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  rms_pkg::rms_status_t status,
  output logic                 in_ready,
  output rms_pkg::rms_cmd_t    cmd
);
  import rms_pkg::*;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_CLOSE,
    ST_DIV,
    ST_ROOT,
    ST_SEND
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      step_r  <= '0;
    end else begin
      case (state_r)
        ST_ACC: begin
          if (in_fire && in_last) begin
            state_r <= ST_CLOSE;
          end
        end
        ST_CLOSE: begin
          state_r <= ST_DIV;
          step_r  <= STEP_W'(MEAN_W - 1);
        end
        ST_DIV: begin
          if (step_r == '0) begin
            state_r <= ST_ROOT;
            step_r  <= STEP_W'(ROOT_STEPS - 1);
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_ROOT: begin
          if (step_r == '0) begin
            state_r <= ST_SEND;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_SEND: begin
          if (status.out_free) begin
            state_r <= ST_ACC;
          end
        end
        default: begin
          state_r <= ST_ACC;
        end
      endcase
    end
  end

  assign in_ready      = (state_r == ST_ACC);
  assign cmd.close     = (state_r == ST_CLOSE);
  assign cmd.div_step  = (state_r == ST_DIV);
  assign cmd.root_step = (state_r == ST_ROOT);
  assign cmd.out_load  = (state_r == ST_SEND) && status.out_free;

endmodule

FILE: rtl/core/rms_dp.sv
`timescale 1ns / 1ps

module rms_dp #(
  parameter int MAX_LEN = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  logic signed [rms_pkg::SAMPLE_W-1:0] in_sample,
  input  rms_pkg::rms_cmd_t                 cmd,
  output rms_pkg::rms_status_t              status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rms_pkg::RMS_W-1:0]         out_rms,
  output logic [rms_pkg::COUNT_W-1:0]       out_sample_count,
  output logic                              out_too_long
);
  import rms_pkg::*;

  localparam int TW    = $clog2(MAX_LEN + 1);      // tally width
  localparam int ACC_W = $clog2(MAX_LEN) + MEAN_W; // holds MAX_LEN squares

  // square stage
  logic [MEAN_W-1:0]         sq_r;
  logic                      sq_vld_r;
  logic signed [2*SAMPLE_W-1:0] prod;

  // accumulator
  logic [ACC_W-1:0] sum_r, sum_nxt;
  logic [TW-1:0]    tally_r, tally_nxt;
  logic             ovf_r, ovf_nxt;
  logic             room;

  // divider / root
  logic [TW-1:0]     rem_r;
  logic [TW-1:0]     div_tally_r;
  logic              ovf_hold_r;
  logic [MEAN_W-1:0] quo_r;      // dividend bits, then quotient, then root remainder
  logic [MEAN_W-1:0] root_r;
  logic [MEAN_W-1:0] digit_r;
  logic [TW:0]       rem2;
  logic              ge;
  logic [MEAN_W-1:0] trial;

  // output register
  logic               out_valid_r;
  logic [RMS_W-1:0]   out_rms_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_ovf_r;

  assign prod = in_sample * in_sample;

  assign room      = (tally_r < TW'(MAX_LEN));
  assign sum_nxt   = (sq_vld_r && room) ? sum_r + ACC_W'(sq_r) : sum_r;
  assign tally_nxt = (sq_vld_r && room) ? tally_r + 1'b1 : tally_r;
  assign ovf_nxt   = ovf_r | (sq_vld_r & ~room);

  assign rem2  = {rem_r, quo_r[MEAN_W-1]};
  assign ge    = (rem2 >= {1'b0, div_tally_r});
  assign trial = root_r + digit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      sum_r    <= '0;
      tally_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      sq_vld_r <= in_fire;
      if (cmd.close) begin
        sum_r   <= '0;
        tally_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        sum_r   <= sum_nxt;
        tally_r <= tally_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sq_r <= prod[MEAN_W-1:0];
    end
    if (cmd.close) begin
      // sum <= tally * 2^30, so the bits above the quotient are below tally
      rem_r       <= TW'(sum_nxt[ACC_W-1:MEAN_W]);
      quo_r       <= sum_nxt[MEAN_W-1:0];
      div_tally_r <= tally_nxt;
      ovf_hold_r  <= ovf_nxt;
      root_r      <= '0;
      digit_r     <= ROOT_TOP;
    end else if (cmd.div_step) begin
      rem_r <= ge ? TW'(rem2 - {1'b0, div_tally_r}) : rem2[TW-1:0];
      quo_r <= {quo_r[MEAN_W-2:0], ge};
    end else if (cmd.root_step) begin
      if (quo_r >= trial) begin
        quo_r  <= quo_r - trial;
        root_r <= (root_r >> 1) + digit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      digit_r <= digit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rms_r <= root_r[RMS_W-1:0];
      out_cnt_r <= COUNT_W'(div_tally_r);
      out_ovf_r <= ovf_hold_r;
    end
  end

  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_rms          = out_rms_r;
  assign out_sample_count = out_cnt_r;
  assign out_too_long     = out_ovf_r;

endmodule

FILE: rtl/core/block_rms_meter_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Beat payload
// in_ch     in   valid / ready  sample (s16 Q1.15), last
// out_ch    out  valid / ready  rms (u16 Q1.15), sample_count (13b), too_long
//
// Samples are taken one a cycle while a block is open. After the beat marked
// last the input stays closed through a settle step for the final square, 31
// restoring division steps, 16 square root steps, and a load into the output
// register. The output register lets a result wait while the next block
// streams in; the load stalls only if the previous result is still untaken.
// Reset (rst_n, synchronous, active low) empties the accumulator and the
// output register.

module block_rms_meter_top #(
  parameter int MAX_LEN = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  rms_in_if.sink     in_ch,
  rms_out_if.source  out_ch
);
  import rms_pkg::*;

  rms_cmd_t    cmd;
  rms_status_t status;
  logic        in_ready;
  logic        in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  // Sequencer: open block, close, divide, root, hand over
  rms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_last  (in_ch.last),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Squarer, accumulator, shared divide/root registers and output register
  rms_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_sample        (in_ch.sample),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_rms          (out_ch.rms),
    .out_sample_count (out_ch.sample_count),
    .out_too_long     (out_ch.too_long)
  );

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over an untaken beat");

  // Input closes straight after the last beat of a block
  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last) |=> (!in_ch.ready && cmd.close))
    else $error("block not closed after last beat");

  // Datapath commands are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // No new sample while the divider or root is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.root_step || cmd.close) |-> !in_ch.ready)
    else $error("input open during result calculation");

endmodule
